/* hdl/dmm_pkg.sv */
// Shared constants, item codes and controller/datapath interface types
// for the dense matrix multiply core. No dependencies.
`timescale 1ns / 1ps

package dmm_pkg;

   // Store geometry and element format.
   localparam int MAX_DIM       = 8;
   localparam int ELEMENT_WIDTH = 16;
   localparam int IDX_W         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W         = $clog2(MAX_DIM + 1);
   localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Arithmetic widths: exact product, exact sum of up to MAX_DIM products.
   localparam int PROD_W  = 2 * ELEMENT_WIDTH;
   localparam int ACC_W   = PROD_W + $clog2(MAX_DIM + 1) + 1;
   localparam int RESULT_W = 32;

   // Fixed field widths of the words on the ports.
   localparam int KIND_W    = 2;
   localparam int POS_W     = 3;
   localparam int VALUE_W   = 16;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 24;   // 3 + 3 + 16 packed, padded to bytes
   localparam int RSP_DATA_W = 40;   // 3 + 3 + 32 packed, padded to bytes

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_LEFT  = 2'd0,
      KIND_LOAD_RIGHT = 2'd1,
      KIND_START      = 2'd2,
      KIND_NONE       = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_M  = 2'd0,
      CSR_INNER_N = 2'd1,
      CSR_COLS_P  = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_left_addr;
      logic [ADDR_W-1:0] rd_right_addr;
      logic              acc_clear;
      logic              out_load;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              out_last;
   } dmm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dmm_status_type;

   // Register values above MAX_DIM act as MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] value);
      if (32'(value) > 32'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(value);
   endfunction

   // Flat store address of an element.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
   endfunction

endpackage

/* hdl/dmm_ctrl.sv */
// Controller of the dense matrix multiply core: dimension registers and the
// sequencer over result elements and inner terms. Depends on dmm_pkg.
`timescale 1ns / 1ps

module dmm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmm_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            req_accept,
   input  logic [dmm_pkg::KIND_W-1:0]      req_kind,
   input  logic [dmm_pkg::POS_W-1:0]       req_row,
   input  logic [dmm_pkg::POS_W-1:0]       req_col,
   output logic                            req_ready,
   output dmm_pkg::dmm_cmd_type            cmd,
   input  dmm_pkg::dmm_status_type         status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [dmm_pkg::CFG_W-1:0]      rows_ff, rows_in;
   logic [dmm_pkg::CFG_W-1:0]      inner_ff, inner_in;
   logic [dmm_pkg::CFG_W-1:0]      cols_ff, cols_in;
   logic [dmm_pkg::DIM_W-1:0]      m_ff, m_in, n_ff, n_in, p_ff, p_in;
   logic [dmm_pkg::IDX_W-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                           drain_ff, drain_in;

   logic                           load_in_range;
   logic                           last_k, last_j, last_i;
   logic [dmm_pkg::DIM_W-1:0]      m_start, n_start, p_start;

   assign m_start = dmm_pkg::clamp_dim(rows_ff);
   assign n_start = dmm_pkg::clamp_dim(inner_ff);
   assign p_start = dmm_pkg::clamp_dim(cols_ff);

   assign load_in_range = (32'(req_row) < 32'(dmm_pkg::MAX_DIM)) &&
                          (32'(req_col) < 32'(dmm_pkg::MAX_DIM));

   assign last_k = (dmm_pkg::DIM_W'(k_ff) + dmm_pkg::DIM_W'(1)) == n_ff;
   assign last_j = (dmm_pkg::DIM_W'(j_ff) + dmm_pkg::DIM_W'(1)) == p_ff;
   assign last_i = (dmm_pkg::DIM_W'(i_ff) + dmm_pkg::DIM_W'(1)) == m_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd               = '0;
      cmd.wr_addr       = dmm_pkg::store_addr(dmm_pkg::IDX_W'(req_row),
                                              dmm_pkg::IDX_W'(req_col));
      cmd.wr_left       = req_accept && load_in_range &&
                          (req_kind == dmm_pkg::KIND_LOAD_LEFT);
      cmd.wr_right      = req_accept && load_in_range &&
                          (req_kind == dmm_pkg::KIND_LOAD_RIGHT);
      cmd.rd_en         = (state_ff == ST_ISSUE) && (n_ff != '0);
      cmd.rd_left_addr  = dmm_pkg::store_addr(i_ff, k_ff);
      cmd.rd_right_addr = dmm_pkg::store_addr(k_ff, j_ff);
      cmd.acc_clear     = req_accept && (req_kind == dmm_pkg::KIND_START);
      cmd.out_load      = (state_ff == ST_EMIT) && status.out_free;
      cmd.out_row       = dmm_pkg::POS_W'(i_ff);
      cmd.out_col       = dmm_pkg::POS_W'(j_ff);
      cmd.out_last      = last_i && last_j;
   end

   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      drain_in = drain_ff;

      if (csr_we) begin
         case (csr_index)
            dmm_pkg::CSR_ROWS_M:  rows_in  = csr_wdata;
            dmm_pkg::CSR_INNER_N: inner_in = csr_wdata;
            dmm_pkg::CSR_COLS_P:  cols_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_kind == dmm_pkg::KIND_START) &&
                (m_start != '0) && (p_start != '0)) begin
               m_in     = m_start;
               n_in     = n_start;
               p_in     = p_start;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (n_ff == '0) begin
               state_in = ST_EMIT;
            end else if (last_k) begin
               k_in     = '0;
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + dmm_pkg::IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // Wait while the read data, then the product, reach the accumulator.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (last_i && last_j) begin
                  state_in = ST_IDLE;
               end else if (last_j) begin
                  j_in     = '0;
                  i_in     = i_ff + dmm_pkg::IDX_W'(1);
                  state_in = ST_ISSUE;
               end else begin
                  j_in     = j_ff + dmm_pkg::IDX_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= dmm_pkg::CFG_W'(8);
         inner_ff <= dmm_pkg::CFG_W'(8);
         cols_ff  <= dmm_pkg::CFG_W'(8);
         m_ff     <= '0;
         n_ff     <= '0;
         p_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         m_ff     <= m_in;
         n_ff     <= n_in;
         p_ff     <= p_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
      end
   end

endmodule

/* hdl/dmm_datapath.sv */
// Datapath of the dense matrix multiply core: element stores, multiplier,
// accumulator, saturation and the result output register. Depends on dmm_pkg.
`timescale 1ns / 1ps

module dmm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dmm_pkg::VALUE_W-1:0]       req_value,
   input  dmm_pkg::dmm_cmd_type              cmd,
   output dmm_pkg::dmm_status_type           status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dmm_pkg::POS_W-1:0]         rsp_row,
   output logic [dmm_pkg::POS_W-1:0]         rsp_col,
   output logic [dmm_pkg::RESULT_W-1:0]      rsp_value,
   output logic                              rsp_sat,
   output logic                              rsp_last
);

   logic signed [dmm_pkg::ELEMENT_WIDTH-1:0] left_mem  [dmm_pkg::STORE_DEPTH];
   logic signed [dmm_pkg::ELEMENT_WIDTH-1:0] right_mem [dmm_pkg::STORE_DEPTH];

   logic signed [dmm_pkg::ELEMENT_WIDTH-1:0] left_rd_ff, right_rd_ff;
   logic                                     rd_valid_ff;
   logic signed [dmm_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic                                     prod_valid_ff;
   logic signed [dmm_pkg::ACC_W-1:0]         acc_ff, acc_in;

   logic                                     out_valid_ff, out_valid_in;
   logic [dmm_pkg::POS_W-1:0]                out_row_ff, out_col_ff;
   logic [dmm_pkg::RESULT_W-1:0]             out_value_ff, out_value_in;
   logic                                     out_sat_ff, out_sat_in;
   logic                                     out_last_ff;

   logic [dmm_pkg::ELEMENT_WIDTH-1:0]        wr_element;
   logic [dmm_pkg::ACC_W-dmm_pkg::RESULT_W:0] acc_top;

   assign wr_element = req_value[dmm_pkg::ELEMENT_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_left) begin
         left_mem[cmd.wr_addr] <= wr_element;
      end
      left_rd_ff <= left_mem[cmd.rd_left_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_right) begin
         right_mem[cmd.wr_addr] <= wr_element;
      end
      right_rd_ff <= right_mem[cmd.rd_right_addr];
   end

   assign prod_in = left_rd_ff * right_rd_ff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear || cmd.out_load) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + {{(dmm_pkg::ACC_W - dmm_pkg::PROD_W){prod_ff[dmm_pkg::PROD_W-1]}},
                            prod_ff};
      end
   end

   // The sum fits the result when all bits from the result's sign upward agree.
   assign acc_top = acc_ff[dmm_pkg::ACC_W-1:dmm_pkg::RESULT_W-1];

   always_comb begin
      out_sat_in   = !((&acc_top) || !(|acc_top));
      out_value_in = acc_ff[dmm_pkg::RESULT_W-1:0];
      if (out_sat_in) begin
         out_value_in = acc_ff[dmm_pkg::ACC_W-1] ?
                        {1'b1, {(dmm_pkg::RESULT_W-1){1'b0}}} :
                        {1'b0, {(dmm_pkg::RESULT_W-1){1'b1}}};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         acc_ff        <= '0;
      end else begin
         rd_valid_ff   <= cmd.rd_en;
         prod_valid_ff <= rd_valid_ff;
         out_valid_ff  <= out_valid_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.out_load) begin
         out_row_ff   <= cmd.out_row;
         out_col_ff   <= cmd.out_col;
         out_value_ff <= out_value_in;
         out_sat_ff   <= out_sat_in;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_value = out_value_ff;
   assign rsp_sat   = out_sat_ff;
   assign rsp_last  = out_last_ff;

endmodule

/* hdl/dense_matrix_multiply_core.sv */
// Top level of the dense matrix multiply core: stream ports, configuration
// port, and the controller and datapath. Depends on dmm_pkg, dmm_ctrl, dmm_datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     tuser: kind; tdata: row, col, element
// rsp_      out        rsp_tvalid/tready     tuser: saturated; tdata: row, col,
//                                            product; tlast: final element
// csr_      in         csr_we (no wait)      csr_index, csr_wdata
//
// A load word writes one element of a store.
// A start word occupies the block until every result element is done: each result
// element issues n reads through the single read port of each store, then waits
// for the multiplier and accumulator to take in the last term, then goes into the
// output register. With n of zero an element skips the reads and the wait.
// Reset is synchronous and active high; it sets all three dimensions to eight.
// A stalled result word holds the sequencer only when the next element is ready.

module dense_matrix_multiply_core (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dmm_pkg::CFG_W-1:0]           csr_wdata,
   // Input words.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata, from bit 0: row_index[2:0], col_index[5:3],
   // element_value[21:6], zero padding[23:22].
   input  logic [dmm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: kind[1:0].
   input  logic [dmm_pkg::KIND_W-1:0]          req_tuser,
   // Result words.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata, from bit 0: out_row[2:0], out_col[5:3],
   // product_value[37:6], zero padding[39:38].
   output logic [dmm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: saturated[0].
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int COL_LO   = dmm_pkg::POS_W;
   localparam int VALUE_LO = 2 * dmm_pkg::POS_W;
   localparam int RSP_USED = VALUE_LO + dmm_pkg::RESULT_W;

   dmm_pkg::dmm_cmd_type              cmd;
   dmm_pkg::dmm_status_type           status;
   logic                              req_accept;
   logic [dmm_pkg::POS_W-1:0]         rsp_row, rsp_col;
   logic [dmm_pkg::RESULT_W-1:0]      rsp_value;

   assign req_accept = req_tvalid && req_tready;

   dmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_kind   (req_tuser),
      .req_row    (req_tdata[COL_LO-1:0]),
      .req_col    (req_tdata[VALUE_LO-1:COL_LO]),
      .req_ready  (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dmm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_tdata[VALUE_LO+dmm_pkg::VALUE_W-1:VALUE_LO]),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_value (rsp_value),
      .rsp_sat   (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   // Pack the result word; the top bits are padding.
   assign rsp_tdata = {{(dmm_pkg::RSP_DATA_W - RSP_USED){1'b0}}, rsp_value, rsp_col, rsp_row};

endmodule

/* test/dmm_product_checker.sv */
// Result checker for the dense matrix multiply core: watches the configuration,
// input and result channels, predicts each result word and compares it.
// Depends on dmm_pkg.
`timescale 1ns / 1ps

module dmm_product_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmm_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // req_tdata, from bit 0: row_index, col_index, element_value, padding.
   input  logic [dmm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: kind.
   input  logic [dmm_pkg::KIND_W-1:0]         req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata, from bit 0: out_row, out_col, product_value, padding.
   input  logic [dmm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: saturated.
   input  logic                               rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 mismatch_count,
   output int                                 pending_results
);
   import dmm_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [31:0]      value;
      logic             sat;
      logic             last;
   } product_elem_type;

   product_elem_type          expected_products[$];
   logic signed [VALUE_W-1:0] left_elems[STORE_DEPTH];
   logic signed [VALUE_W-1:0] right_elems[STORE_DEPTH];
   logic [CFG_W-1:0]          rows_cfg;
   logic [CFG_W-1:0]          inner_cfg;
   logic [CFG_W-1:0]          cols_cfg;
   int                        errors;

   function automatic int dim_limit(input logic [CFG_W-1:0] value);
      return (int'(value) > MAX_DIM) ? MAX_DIM : int'(value);
   endfunction

   // Queue every element of the product in row-major order.
   function automatic void queue_products();
      int               m;
      int               n;
      int               p;
      longint           acc;
      product_elem_type elem;
      m = dim_limit(rows_cfg);
      n = dim_limit(inner_cfg);
      p = dim_limit(cols_cfg);
      for (int i = 0; i < m; i++) begin
         for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++) begin
               acc += longint'(left_elems[i * MAX_DIM + k]) *
                      longint'(right_elems[k * MAX_DIM + j]);
            end
            elem.row  = POS_W'(i);
            elem.col  = POS_W'(j);
            elem.sat  = 1'b0;
            if (acc > 64'sd2147483647) begin
               elem.value = 32'h7FFF_FFFF;
               elem.sat   = 1'b1;
            end else if (acc < -64'sd2147483648) begin
               elem.value = 32'h8000_0000;
               elem.sat   = 1'b1;
            end else begin
               elem.value = acc[31:0];
            end
            elem.last = (i == m - 1) && (j == p - 1);
            expected_products.push_back(elem);
         end
      end
   endfunction

   task automatic note_mismatch(input string field, input longint want, input longint got);
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      product_elem_type  want;
      logic [ADDR_W-1:0] addr;
      if (reset) begin
         rows_cfg  = 4'd8;
         inner_cfg = 4'd8;
         cols_cfg  = 4'd8;
         errors    = 0;
         expected_products.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS_M:  rows_cfg  = csr_wdata;
               CSR_INNER_N: inner_cfg = csr_wdata;
               CSR_COLS_P:  cols_cfg  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            addr = ADDR_W'(req_tdata[2:0] * MAX_DIM + req_tdata[5:3]);
            case (kind_type'(req_tuser))
               KIND_LOAD_LEFT:  left_elems[addr]  = req_tdata[21:6];
               KIND_LOAD_RIGHT: right_elems[addr] = req_tdata[21:6];
               KIND_START:      queue_products();
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_products.size() == 0) begin
               errors++;
               $display("%0t ns: result word with none expected, actual row %0d col %0d %s %0d",
                        $time, rsp_tdata[2:0], rsp_tdata[5:3], "value",
                        $signed(rsp_tdata[37:6]));
            end else begin
               want = expected_products.pop_front();
               if (rsp_tdata[2:0] !== want.row)
                  note_mismatch("out_row", want.row, rsp_tdata[2:0]);
               if (rsp_tdata[5:3] !== want.col)
                  note_mismatch("out_col", want.col, rsp_tdata[5:3]);
               if (rsp_tdata[37:6] !== want.value)
                  note_mismatch("product_value", $signed(want.value), $signed(rsp_tdata[37:6]));
               if (rsp_tuser !== want.sat)
                  note_mismatch("saturated", want.sat, rsp_tuser);
               if (rsp_tlast !== want.last)
                  note_mismatch("last", want.last, rsp_tlast);
            end
         end
      end
      mismatch_count  <= errors;
      pending_results <= expected_products.size();
   end

endmodule

/* test/tb_dense_matrix_multiply_core.sv */
// Testbench top for the dense matrix multiply core: drives load and start words,
// stalls the result channel and gives the verdict. Depends on dmm_pkg,
// dense_matrix_multiply_core and dmm_product_checker.
`timescale 1ns / 1ps

module tb_dense_matrix_multiply_core;
   import dmm_pkg::*;

   // Roughly this many load and start words are sent in total.
   localparam int WORD_TARGET = 500;
   // A start word keeps the block busy until its last result has gone into the
   // output register; one that yields no result never leaves the idle state. Waiting
   // this long after the last result gives any stray result word time to show.
   localparam int SETTLE_CYCLES = 800;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct {
      kind_type         kind;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [VALUE_W-1:0] value;
   } req_word_type;

   typedef enum {SINK_FREE, SINK_CHOPPY, SINK_SLUGGISH} sink_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int mismatch_count;
   int pending_results;
   int cycle_count = 0;
   int burst_left  = 0;
   int words_sent  = 0;

   // Clamped dimensions currently programmed, so that the stimulus knows which
   // store entries a start word will read.
   int m_dim = MAX_DIM;
   int n_dim = MAX_DIM;
   int p_dim = MAX_DIM;

   // Entries written so far. A start word must never read an entry that has not
   // been written, as the store contents are undefined until then.
   bit left_loaded[STORE_DEPTH];
   bit right_loaded[STORE_DEPTH];

   sink_mode_type sink_mode = SINK_FREE;
   int            sink_left = 0;

   dense_matrix_multiply_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dmm_product_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The result side switches between stretches of constant readiness, random
   // readiness and long stalls, each stretch of random length, independently of
   // whatever the sender is doing.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 2));
            sink_left = $urandom_range(8, 200);
         end
         sink_left--;
         case (sink_mode)
            SINK_FREE:   rsp_tready <= 1'b1;
            SINK_CHOPPY: rsp_tready <= 1'($urandom_range(0, 1));
            default:     rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // In a third of the picks one of the two extremes of Q8.8, so that sums saturate
   // often enough, otherwise any 16-bit pattern.
   function automatic logic [VALUE_W-1:0] pick_element();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Dimensions are mostly small so that the run stays short; now and then a
   // zero, the full eight, or a value above eight that the block clamps.
   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0:       return 4'd0;
         1:       return 4'd8;
         2:       return CFG_W'($urandom_range(9, 15));
         default: return CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Offer one word and hold it until it is taken. Words go out in bursts of
   // random length; between bursts the valid line drops for a random gap, and
   // some bursts follow one another with no gap at all.
   task automatic send_word(input kind_type kind, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, value, col, row};
      do @(posedge clock); while (!req_tready);
      case (kind)
         KIND_LOAD_LEFT:  left_loaded[row * MAX_DIM + col]  = 1'b1;
         KIND_LOAD_RIGHT: right_loaded[row * MAX_DIM + col] = 1'b1;
         default: ;
      endcase
      if (kind != KIND_NONE) words_sent++;
   endtask

   // Stop offering words, wait for every predicted result to come back, then wait out
   // the settle time so that any stray result word would still be seen.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program all three dimensions while the block is idle, and sometimes poke the
   // unused register index as well, which must change nothing.
   task automatic write_dims(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                             input logic [CFG_W-1:0] p, input bit poke_unused);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS_M;
      csr_wdata <= m;
      @(posedge clock);
      csr_index <= CSR_INNER_N;
      csr_wdata <= n;
      @(posedge clock);
      csr_index <= CSR_COLS_P;
      csr_wdata <= p;
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= CFG_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      m_dim = (int'(m) > MAX_DIM) ? MAX_DIM : int'(m);
      n_dim = (int'(n) > MAX_DIM) ? MAX_DIM : int'(n);
      p_dim = (int'(p) > MAX_DIM) ? MAX_DIM : int'(p);
      burst_left = 0;
   endtask

   // One well-formed sequence: load every entry the current shape needs that is
   // still unwritten, refresh a random share of the others, mix in a few ignored
   // words and stray loads, shuffle the lot, and finish with a start word.
   task automatic run_round();
      req_word_type batch[$];
      req_word_type w;
      req_word_type tmp;
      int           j;
      for (int r = 0; r < m_dim; r++) begin
         for (int k = 0; k < n_dim; k++) begin
            if (!left_loaded[r * MAX_DIM + k] || $urandom_range(0, 2) == 0) begin
               batch.push_back('{KIND_LOAD_LEFT, POS_W'(r), POS_W'(k), pick_element()});
            end
         end
      end
      for (int k = 0; k < n_dim; k++) begin
         for (int c = 0; c < p_dim; c++) begin
            if (!right_loaded[k * MAX_DIM + c] || $urandom_range(0, 2) == 0) begin
               batch.push_back('{KIND_LOAD_RIGHT, POS_W'(k), POS_W'(c), pick_element()});
            end
         end
      end
      repeat ($urandom_range(0, 3)) begin
         w.row   = POS_W'($urandom);
         w.col   = POS_W'($urandom);
         w.value = pick_element();
         case ($urandom_range(0, 2))
            0:       w.kind = KIND_NONE;
            1:       w.kind = KIND_LOAD_LEFT;
            default: w.kind = KIND_LOAD_RIGHT;
         endcase
         batch.push_back(w);
      end
      for (int i = batch.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = batch[i];
         batch[i] = batch[j];
         batch[j] = tmp;
      end
      foreach (batch[q]) send_word(batch[q].kind, batch[q].row, batch[q].col, batch[q].value);
      // The position and value fields of a start word carry nothing.
      send_word(KIND_START, POS_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A 2 x 3 by 3 x 2 product built from the extremes of Q8.8. The first result
      // row overflows upwards and then downwards, the second cancels to zero.
      write_dims(4'd2, 4'd3, 4'd2, 1'b1);
      for (int k = 0; k < 3; k++) begin
         send_word(KIND_LOAD_LEFT, 3'd0, POS_W'(k), 16'h8000);
         send_word(KIND_LOAD_RIGHT, POS_W'(k), 3'd0, 16'h8000);
         send_word(KIND_LOAD_RIGHT, POS_W'(k), 3'd1, 16'h7FFF);
      end
      send_word(KIND_LOAD_LEFT, 3'd1, 3'd0, 16'h7FFF);
      send_word(KIND_LOAD_LEFT, 3'd1, 3'd1, 16'h8000);
      send_word(KIND_LOAD_LEFT, 3'd1, 3'd2, 16'h0001);
      // The far corner of the store, and an ignored word with every field at ones.
      send_word(KIND_LOAD_LEFT, 3'd7, 3'd7, 16'h0000);
      send_word(KIND_NONE, 3'd7, 3'd7, 16'hFFFF);
      send_word(KIND_START, 3'd0, 3'd0, 16'h0000);

      // No rows, then no columns: the start word must produce nothing.
      write_dims(4'd0, 4'd3, 4'd2, 1'b0);
      send_word(KIND_START, 3'd0, 3'd0, 16'h0000);
      write_dims(4'd2, 4'd3, 4'd0, 1'b0);
      send_word(KIND_START, 3'd0, 3'd0, 16'h0000);

      // An empty inner dimension gives zero sums without reading either store.
      write_dims(4'd1, 4'd0, 4'd2, 1'b0);
      send_word(KIND_START, 3'd0, 3'd0, 16'h0000);

      // Random phases, each with a fresh shape and one to three sequences.
      while (words_sent < WORD_TARGET) begin
         write_dims(pick_dim(), pick_dim(), pick_dim(), $urandom_range(0, 7) == 0);
         repeat ($urandom_range(1, 3)) run_round();
      end

      // Everything has been taken; wait for the last results and for any stray
      // word the block might still emit.
      drain();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/dmm_pkg.sv
hdl/dmm_ctrl.sv
hdl/dmm_datapath.sv
hdl/dense_matrix_multiply_core.sv
test/dmm_product_checker.sv
test/tb_dense_matrix_multiply_core.sv
